[hdl/coo2csr_pkg.sv]
// Shared types and constants of the COO to CSR converter.
// Used by the interfaces and every module; depends on nothing.
package coo2csr_pkg;

	localparam int ROW_W         = 11;
	localparam int COL_W         = 31;
	localparam int VAL_W         = 64;
	localparam int POS_W         = 13;
	localparam int NROWS_W       = 11;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 3;
	localparam int MAX_ROWS_DEF  = 1024;
	localparam int MAX_ENT_DEF   = 4096;
	localparam int NROWS_RESET   = 1024;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W        = $clog2(QDEPTH + 1);

	localparam logic [ADDR_W-1:0] ADDR_NUM_ROWS = 3'd0;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_DROP,
		OP_DRAIN
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic converting;
	} stat_t;

endpackage

[hdl/coo2csr_if.sv]
// Word channels of the converter: input triples and drain requests, results.
// Depends on coo2csr_pkg.
interface coo2csr_in_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [coo2csr_pkg::ROW_W-1:0]  row;
	logic [coo2csr_pkg::COL_W-1:0]  col;
	logic [coo2csr_pkg::VAL_W-1:0]  value;

	modport source(output valid, kind, row, col, value, input ready);
	modport sink(input valid, kind, row, col, value, output ready);
endinterface

interface coo2csr_out_if;
	logic                           valid;
	logic                           ready;
	logic                           is_entry;
	logic [coo2csr_pkg::POS_W-1:0]  position;
	logic [coo2csr_pkg::POS_W-1:0]  row_start;
	logic [coo2csr_pkg::COL_W-1:0]  col_index;
	logic [coo2csr_pkg::VAL_W-1:0]  entry_value;
	logic                           dropped;
	logic                           last;

	modport source(output valid, is_entry, position, row_start, col_index, entry_value,
		dropped, last, input ready);
	modport sink(input valid, is_entry, position, row_start, col_index, entry_value,
		dropped, last, output ready);
endinterface

[hdl/coo2csr_front.sv]
// Front end: takes input words and classifies them into load, drop or drain commands.
// Depends on coo2csr_pkg and coo2csr_in_if.
module coo2csr_front #(
	parameter int MAX_ROWS = coo2csr_pkg::MAX_ROWS_DEF
) (
	coo2csr_in_if.sink                      in,
	input  logic [coo2csr_pkg::NROWS_W-1:0] num_rows,
	input  logic                            q_ready,
	output logic                            push,
	output coo2csr_pkg::cmd_t               cmd
);

	logic row_bad;

	assign row_bad = (in.row == '0) || (32'(in.row) > 32'(num_rows))
		|| (32'(in.row) > MAX_ROWS);

	assign in.ready = q_ready;
	assign push     = in.valid && q_ready;

	always_comb begin
		cmd.row   = in.row;
		cmd.col   = in.col;
		cmd.value = in.value;
		if (in.kind) begin
			cmd.op = coo2csr_pkg::OP_DRAIN;
		end else if (row_bad) begin
			cmd.op = coo2csr_pkg::OP_DROP;
		end else begin
			cmd.op = coo2csr_pkg::OP_LOAD;
		end
	end

endmodule

[hdl/coo2csr_queue.sv]
// Short command queue between front and back end.
// Depends on coo2csr_pkg.
module coo2csr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  coo2csr_pkg::cmd_t push_cmd,
	output logic              ready,
	output logic              valid,
	output coo2csr_pkg::cmd_t cmd,
	input  logic              pop
);

	coo2csr_pkg::cmd_t                 slot_q [coo2csr_pkg::QDEPTH];
	logic [coo2csr_pkg::QPTR_W-1:0]    wr_q;
	logic [coo2csr_pkg::QPTR_W-1:0]    rd_q;
	logic [coo2csr_pkg::QCNT_W-1:0]    cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign ready   = cnt_q != coo2csr_pkg::QCNT_W'(coo2csr_pkg::QDEPTH);
	assign valid   = cnt_q != '0;
	assign cmd     = slot_q[rd_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == coo2csr_pkg::QPTR_W'(coo2csr_pkg::QDEPTH - 1)) ? '0
					: wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == coo2csr_pkg::QPTR_W'(coo2csr_pkg::QDEPTH - 1)) ? '0
					: rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/coo2csr_back.sv]
// Back end: row count, triple and sorted stores, conversion sequencer and result register.
// Depends on coo2csr_pkg and coo2csr_out_if.
module coo2csr_back #(
	parameter int MAX_ROWS    = coo2csr_pkg::MAX_ROWS_DEF,
	parameter int MAX_ENTRIES = coo2csr_pkg::MAX_ENT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [coo2csr_pkg::NROWS_W-1:0] num_rows,
	input  logic                            cmd_valid,
	input  coo2csr_pkg::cmd_t               cmd,
	output logic                            pop,
	coo2csr_out_if.source                   out,
	output coo2csr_pkg::stat_t              stat
);

	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int EW  = $clog2(MAX_ENTRIES + 1);
	localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PW  = $clog2(MAX_ROWS + MAX_ENTRIES + 1);
	localparam int CW  = coo2csr_pkg::COL_W;
	localparam int VW  = coo2csr_pkg::VAL_W;
	localparam int SW  = CW + VW;
	localparam int PDW = RW + SW;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LD_WR,
		S_PF_RD,
		S_PF_WR,
		S_SC_RD,
		S_SC_RC,
		S_SC_WR,
		S_DR_RD,
		S_DR_OUT
	} state_t;

	logic [EW-1:0]  rc_mem [MAX_ROWS + 1];
	logic [PDW-1:0] pd_mem [MAX_ENTRIES];
	logic [SW-1:0]  sr_mem [MAX_ENTRIES];

	state_t         state_q;
	logic [RW-1:0]  idx_q;
	logic [RW-1:0]  n_q;
	logic [RW-1:0]  cur_row_q;
	logic [EW-1:0]  sum_q;
	logic [EW-1:0]  cnt_q;
	logic [EW-1:0]  j_q;
	logic [PW-1:0]  pos_q;
	logic           phase_q;
	logic           drop_q;
	logic           out_valid_q;
	logic [EW-1:0]  rc_rd_q;
	logic [PDW-1:0] pd_rd_q;
	logic [SW-1:0]  sr_rd_q;

	logic           rc_re, rc_we, pd_re, pd_we, sr_re, sr_we, out_load;
	logic [RW-1:0]  rc_ra, rc_wa, cmd_row, n_sel, pd_row;
	logic [EW-1:0]  rc_wd;
	logic [PDW-1:0] pd_wd;
	logic [SW-1:0]  sr_wd;
	logic [PW-1:0]  k;
	logic [CW-1:0]  pd_col;
	logic [VW-1:0]  pd_val;
	logic           is_ptr, last_w, load_ok, in_range;

	assign cmd_row  = RW'(cmd.row);
	assign n_sel    = (32'(num_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(num_rows);
	assign pd_row   = pd_rd_q[PDW-1 -: RW];
	assign pd_col   = pd_rd_q[SW-1 -: CW];
	assign pd_val   = pd_rd_q[VW-1:0];
	assign k        = pos_q - PW'(n_q) - PW'(1);
	assign is_ptr   = pos_q <= PW'(n_q);
	assign last_w   = pos_q >= (PW'(n_q) + PW'(cnt_q));
	assign load_ok  = !phase_q && (cnt_q != EW'(MAX_ENTRIES));
	assign in_range = idx_q <= n_q;
	assign pd_wd    = {cmd_row, cmd.col, cmd.value};
	assign sr_wd    = {pd_col - CW'(1), pd_val};

	assign stat.clearing   = state_q == S_CLR;
	assign stat.converting = (state_q == S_PF_RD) || (state_q == S_PF_WR)
		|| (state_q == S_SC_RD) || (state_q == S_SC_RC) || (state_q == S_SC_WR);

	assign out.valid = out_valid_q;

	always_comb begin
		rc_re    = 1'b0;
		rc_ra    = idx_q;
		rc_we    = 1'b0;
		rc_wa    = idx_q;
		rc_wd    = '0;
		pd_re    = 1'b0;
		pd_we    = 1'b0;
		sr_re    = 1'b0;
		sr_we    = 1'b0;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_CLR: begin
				rc_we = 1'b1;
			end
			S_IDLE: begin
				pop = cmd_valid;
				if (cmd_valid && cmd.op == coo2csr_pkg::OP_LOAD && load_ok) begin
					pd_we = 1'b1;
					rc_re = 1'b1;
					rc_ra = cmd_row;
				end
			end
			S_LD_WR: begin
				rc_we = 1'b1;
				rc_wa = cur_row_q;
				rc_wd = rc_rd_q + EW'(1);
			end
			S_PF_RD: begin
				rc_re = 1'b1;
			end
			S_PF_WR: begin
				rc_we = 1'b1;
				rc_wd = in_range ? sum_q : '0;
			end
			S_SC_RD: begin
				pd_re = j_q != cnt_q;
			end
			S_SC_RC: begin
				rc_re = 1'b1;
				rc_ra = pd_row;
			end
			S_SC_WR: begin
				if (pd_row <= n_q) begin
					sr_we = 1'b1;
					rc_we = 1'b1;
					rc_wa = pd_row;
					rc_wd = rc_rd_q + EW'(1);
				end
			end
			S_DR_RD: begin
				if (is_ptr) begin
					rc_re = 1'b1;
					rc_ra = pos_q[RW-1:0];
				end else begin
					sr_re = 1'b1;
				end
			end
			S_DR_OUT: begin
				out_load = !out_valid_q || out.ready;
				if (out_load && is_ptr) begin
					rc_we = 1'b1;
					rc_wa = pos_q[RW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rc_re) begin
			rc_rd_q <= rc_mem[rc_ra];
		end
		if (rc_we) begin
			rc_mem[rc_wa] <= rc_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (pd_re) begin
			pd_rd_q <= pd_mem[j_q[AW-1:0]];
		end
		if (pd_we) begin
			pd_mem[cnt_q[AW-1:0]] <= pd_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (sr_re) begin
			sr_rd_q <= sr_mem[k[AW-1:0]];
		end
		if (sr_we) begin
			sr_mem[rc_rd_q[AW-1:0]] <= sr_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			idx_q           <= '0;
			n_q             <= '0;
			cur_row_q       <= '0;
			sum_q           <= '0;
			cnt_q           <= '0;
			j_q             <= '0;
			pos_q           <= '0;
			phase_q         <= 1'b0;
			drop_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			out.is_entry    <= 1'b0;
			out.position    <= '0;
			out.row_start   <= '0;
			out.col_index   <= '0;
			out.entry_value <= '0;
			out.dropped     <= 1'b0;
			out.last        <= 1'b0;
		end else begin
			if (out_valid_q && out.ready && state_q != S_DR_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (idx_q == RW'(MAX_ROWS)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + RW'(1);
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							coo2csr_pkg::OP_LOAD: begin
								if (load_ok) begin
									cur_row_q <= cmd_row;
									cnt_q     <= cnt_q + EW'(1);
									state_q   <= S_LD_WR;
								end else begin
									drop_q <= 1'b1;
								end
							end
							coo2csr_pkg::OP_DRAIN: begin
								if (phase_q) begin
									state_q <= S_DR_RD;
								end else begin
									n_q     <= n_sel;
									idx_q   <= RW'(1);
									sum_q   <= '0;
									state_q <= S_PF_RD;
								end
							end
							default: begin
								drop_q <= 1'b1;
							end
						endcase
					end
				end
				S_LD_WR: begin
					state_q <= S_IDLE;
				end
				S_PF_RD: begin
					state_q <= S_PF_WR;
				end
				S_PF_WR: begin
					if (in_range) begin
						sum_q <= sum_q + rc_rd_q;
					end else if (rc_rd_q != '0) begin
						drop_q <= 1'b1;
					end
					if (idx_q == RW'(MAX_ROWS)) begin
						j_q     <= '0;
						state_q <= S_SC_RD;
					end else begin
						idx_q   <= idx_q + RW'(1);
						state_q <= S_PF_RD;
					end
				end
				S_SC_RD: begin
					if (j_q == cnt_q) begin
						cnt_q   <= sum_q;
						pos_q   <= '0;
						phase_q <= 1'b1;
						state_q <= S_DR_RD;
					end else begin
						state_q <= S_SC_RC;
					end
				end
				S_SC_RC: begin
					state_q <= S_SC_WR;
				end
				S_SC_WR: begin
					j_q     <= j_q + EW'(1);
					state_q <= S_SC_RD;
				end
				S_DR_RD: begin
					state_q <= S_DR_OUT;
				end
				S_DR_OUT: begin
					if (out_load) begin
						out_valid_q     <= 1'b1;
						out.is_entry    <= !is_ptr;
						out.position    <= is_ptr ? coo2csr_pkg::POS_W'(pos_q)
							: coo2csr_pkg::POS_W'(k);
						out.row_start   <= is_ptr ? coo2csr_pkg::POS_W'(rc_rd_q) : '0;
						out.col_index   <= is_ptr ? '0 : sr_rd_q[SW-1 -: CW];
						out.entry_value <= is_ptr ? '0 : sr_rd_q[VW-1:0];
						out.dropped     <= drop_q;
						out.last        <= last_w;
						if (last_w) begin
							phase_q <= 1'b0;
							cnt_q   <= '0;
							pos_q   <= '0;
						end else begin
							pos_q <= pos_q + PW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/coo_to_csr_converter.sv]
// COO to CSR converter, top level. Depends on coo2csr_pkg, the channel interfaces,
// coo2csr_front, coo2csr_queue and coo2csr_back.
// Load words carry one-based (row, col, value) triples; drain words each return one result:
// min(num_rows, MAX_ROWS)+1 row pointers, then the entries in row order with zero-based
// columns, the final word flagged last. Words enter a two-deep command queue and the back
// end works through them one at a time over a single-port row count memory: a load reads
// the row count, then writes it back incremented; a drain result reads its pointer or
// entry. The first drain of a batch runs the conversion first: a prefix pass over the row
// counts, then a scatter of each stored triple. After reset a clearing pass over all
// MAX_ROWS+1 row counts precedes the first queued word; register writes are taken throughout.
module coo_to_csr_converter #(
	parameter int MAX_ROWS    = coo2csr_pkg::MAX_ROWS_DEF,
	parameter int MAX_ENTRIES = coo2csr_pkg::MAX_ENT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	coo2csr_in_if.sink                      in,
	coo2csr_out_if.source                   out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [coo2csr_pkg::ADDR_W-1:0]  paddr,
	input  logic [coo2csr_pkg::DATA_W-1:0]  pwdata,
	output logic [coo2csr_pkg::DATA_W-1:0]  prdata,
	output logic                            pready
);

	logic [coo2csr_pkg::NROWS_W-1:0] num_rows_q;
	logic                            push, q_ready, q_valid, pop;
	coo2csr_pkg::cmd_t               push_cmd, q_cmd;
	coo2csr_pkg::stat_t              stat;

	assign pready = 1'b1;
	assign prdata = (paddr == coo2csr_pkg::ADDR_NUM_ROWS)
		? coo2csr_pkg::DATA_W'(num_rows_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= coo2csr_pkg::NROWS_W'(coo2csr_pkg::NROWS_RESET);
		end else if (psel && penable && pwrite && pready
			&& paddr == coo2csr_pkg::ADDR_NUM_ROWS) begin
			num_rows_q <= pwdata[coo2csr_pkg::NROWS_W-1:0];
		end
	end

	coo2csr_front #(.MAX_ROWS(MAX_ROWS)) u_front (
		.in       (in),
		.num_rows (num_rows_q),
		.q_ready  (q_ready),
		.push     (push),
		.cmd      (push_cmd)
	);

	coo2csr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.ready    (q_ready),
		.valid    (q_valid),
		.cmd      (q_cmd),
		.pop      (pop)
	);

	coo2csr_back #(.MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_rows  (num_rows_q),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.pop       (pop),
		.out       (out),
		.stat      (stat)
	);

	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.dropped |=> !out.valid || out.dropped)
		else $error("drop flag cleared on a later result");

	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && out.last |=>
		!out.valid || (!out.is_entry && out.position == '0))
		else $error("drain after last word did not restart at row pointer zero");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !stat.converting && !out.valid)
		else $error("activity during clearing pass");

endmodule

[dv/tb_coo_to_csr_converter.sv]
`timescale 1ns / 100ps
// Self-checking testbench of coo_to_csr_converter: loads triples, drains CSR words and
// checks each result word against a built-in predictor of the conversion.
// Depends on coo2csr_pkg, the channel interfaces and the converter RTL.
module tb_coo_to_csr_converter;

	localparam int ROW_W       = coo2csr_pkg::ROW_W;
	localparam int COL_W       = coo2csr_pkg::COL_W;
	localparam int VAL_W       = coo2csr_pkg::VAL_W;
	localparam int POS_W       = coo2csr_pkg::POS_W;
	localparam int NROWS_W     = coo2csr_pkg::NROWS_W;
	localparam int ADDR_W      = coo2csr_pkg::ADDR_W;
	localparam int DATA_W      = coo2csr_pkg::DATA_W;
	localparam int NROWS_RESET = coo2csr_pkg::NROWS_RESET;
	localparam logic [ADDR_W-1:0] ADDR_NUM_ROWS = coo2csr_pkg::ADDR_NUM_ROWS;

	localparam int MAXR       = coo2csr_pkg::MAX_ROWS_DEF;
	localparam int MAXE       = coo2csr_pkg::MAX_ENT_DEF;
	localparam int ROWS_TOP   = (1 << NROWS_W) - 1;
	localparam int SETTLE     = 1100;
	localparam int CYCLE_CAP  = 3000000;
	localparam int RAND_ITEMS = 1450;
	localparam bit KIND_LOAD  = 1'b0;
	localparam bit KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic             is_entry;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] row_start;
		logic [COL_W-1:0] col_index;
		logic [VAL_W-1:0] entry_value;
		logic             dropped;
		logic             last;
	} csr_word_t;

	typedef struct {
		bit               kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
		bit               typed;
		csr_word_t        res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;

	coo2csr_in_if  in_ch();
	coo2csr_out_if out_ch();

	coo_to_csr_converter dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	int unsigned     cfg_rows;
	int unsigned     row_cnt [0:MAXR];
	int unsigned     cursor_at [0:MAXR];
	int unsigned     pend_row [0:MAXE-1];
	logic [COL_W-1:0] pend_col [0:MAXE-1];
	logic [VAL_W-1:0] pend_val [0:MAXE-1];
	logic [COL_W-1:0] csr_col [0:MAXE-1];
	logic [VAL_W-1:0] csr_val [0:MAXE-1];
	int unsigned     stored, drain_pos, drain_rows;
	bit              draining, drop_seen;

	csr_word_t csr_expected[$];
	int        errors;
	int        mismatches;
	int        words_seen;
	int        items_sent;
	bit        fast_send;
	bit        long_hold;

	function automatic int unsigned eff_rows();
		return (cfg_rows > MAXR) ? MAXR : cfg_rows;
	endfunction

	function automatic void build_csr();
		int unsigned n, r, at;
		n = eff_rows();
		drain_rows = n;
		row_cnt[0] = 0;
		for (int i = 1; i <= n; i++)
			row_cnt[i] += row_cnt[i-1];
		for (int i = n + 1; i <= MAXR; i++) begin
			if (row_cnt[i] != 0)
				drop_seen = 1;
			row_cnt[i] = 0;
		end
		for (int i = 1; i <= n; i++)
			cursor_at[i] = row_cnt[i-1];
		for (int i = 0; i < stored; i++) begin
			r = pend_row[i];
			if (r <= n) begin
				at = cursor_at[r];
				if (at < MAXE) begin
					csr_col[at] = pend_col[i] - COL_W'(1);
					csr_val[at] = pend_val[i];
				end
				cursor_at[r] = at + 1;
			end
		end
		stored = row_cnt[n];
		drain_pos = 0;
		draining = 1;
	endfunction

	function automatic bit predict_word(bit kind, logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col, logic [VAL_W-1:0] value, output csr_word_t res);
		int unsigned p, k;
		res = '0;
		if (kind == KIND_LOAD) begin
			if (draining || row == 0 || row > eff_rows() || stored >= MAXE) begin
				drop_seen = 1;
				return 0;
			end
			pend_row[stored] = 32'(row);
			pend_col[stored] = col;
			pend_val[stored] = value;
			row_cnt[row]++;
			stored++;
			return 0;
		end
		if (!draining)
			build_csr();
		p = drain_pos;
		if (p <= drain_rows) begin
			res.position  = p[POS_W-1:0];
			res.row_start = row_cnt[p][POS_W-1:0];
		end else begin
			k = p - drain_rows - 1;
			if (k >= MAXE)
				k = MAXE - 1;
			res.is_entry    = 1'b1;
			res.position    = k[POS_W-1:0];
			res.col_index   = csr_col[k];
			res.entry_value = csr_val[k];
		end
		res.dropped = drop_seen;
		if (p >= drain_rows + stored) begin
			res.last = 1'b1;
			for (int i = 0; i <= MAXR; i++)
				row_cnt[i] = 0;
			stored = 0;
			drain_pos = 0;
			draining = 0;
		end else
			drain_pos = p + 1;
		return 1;
	endfunction

	function automatic void report(string what, csr_word_t exp_w, csr_word_t got_w);
		errors++;
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %p got %p", what, exp_w, got_w);
	endfunction

	task automatic send_word(bit kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
			logic [VAL_W-1:0] value, bit typed = 0, csr_word_t typed_res = '0);
		int gap;
		csr_word_t res;
		gap = fast_send ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind  <= kind;
		in_ch.row   <= row;
		in_ch.col   <= col;
		in_ch.value <= value;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (predict_word(kind, row, col, value, res))
			csr_expected.push_back(typed ? typed_res : res);
	endtask

	task automatic idle_word();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_settled();
		in_ch.valid <= 1'b0;
		while (csr_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_read_check(int unsigned want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_NUM_ROWS;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[NROWS_W-1:0] !== want[NROWS_W-1:0]) begin
			errors++;
			$display("num_rows readback: expected %0d got %0d", want, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_rows(int unsigned n);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_NUM_ROWS;
		pwdata  <= n;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		cfg_rows = n & 32'h7FF;
		@(posedge clk);
		reg_read_check(cfg_rows);
		@(posedge clk);
	endtask

	function automatic logic [COL_W-1:0] rand_col();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COL_W'(1);
			2: return '1;
			default: return COL_W'($urandom());
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] rand_row();
		int unsigned n;
		n = eff_rows();
		if (n > 0 && $urandom_range(0, 99) < 88)
			return ROW_W'($urandom_range(1, n));
		case ($urandom_range(0, 2))
			0: return '0;
			1: return '1;
			default: return ROW_W'($urandom_range(n + 1, 2047));
		endcase
	endfunction

	function automatic csr_word_t rp(int p, int rs, bit d, bit l = 0);
		csr_word_t w;
		w = '0;
		w.position  = POS_W'(p);
		w.row_start = POS_W'(rs);
		w.dropped   = d;
		w.last      = l;
		return w;
	endfunction

	function automatic csr_word_t ent(int p, logic [COL_W-1:0] c, logic [VAL_W-1:0] v,
			bit d, bit l = 0);
		csr_word_t w;
		w = '0;
		w.is_entry    = 1'b1;
		w.position    = POS_W'(p);
		w.col_index   = c;
		w.entry_value = v;
		w.dropped     = d;
		w.last        = l;
		return w;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int stall;
		csr_word_t got_w, exp_w;
		out_ch.ready <= 1'b0;
		words_seen = 0;
		forever begin
			stall = ((words_seen / 64) % 3 == 1) ? 0 : $urandom_range(0, 8);
			if (long_hold) begin
				stall     = 600;
				long_hold = 0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got_w = '{out_ch.is_entry, out_ch.position, out_ch.row_start, out_ch.col_index,
				out_ch.entry_value, out_ch.dropped, out_ch.last};
			words_seen++;
			if (csr_expected.size() == 0)
				report("unexpected word", '0, got_w);
			else begin
				exp_w = csr_expected.pop_front();
				if (got_w !== exp_w)
					report("word mismatch", exp_w, got_w);
			end
		end
	end

	initial begin
		dir_row_t dir[$];
		int loads, batch;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_ch.valid <= 1'b0;
		in_ch.kind  <= KIND_LOAD;
		in_ch.row   <= '0;
		in_ch.col   <= '0;
		in_ch.value <= '0;
		errors = 0;
		mismatches = 0;
		items_sent = 0;
		fast_send = 0;
		long_hold = 0;
		cfg_rows = NROWS_RESET;
		for (int i = 0; i <= MAXR; i++)
			row_cnt[i] = 0;
		stored = 0;
		drain_pos = 0;
		drain_rows = 0;
		draining = 0;
		drop_seen = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_read_check(NROWS_RESET);
		@(posedge clk);
		set_rows(2);

		dir.push_back('{KIND_LOAD, 11'd1, 31'd1, 64'd0, 1'b0, '0});
		dir.push_back('{KIND_LOAD, 11'd2, '1, '1, 1'b0, '0});
		dir.push_back('{KIND_LOAD, 11'd1, 31'd0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, '0});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1, rp(0, 0, 1'b0)});
		dir.push_back('{KIND_LOAD, 11'd1, 31'd3, 64'd3, 1'b0, '0});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1, rp(1, 2, 1'b1)});
		dir.push_back('{KIND_DRAIN, '1, '1, '1, 1'b1, rp(2, 3, 1'b1)});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1,
			ent(0, 31'd0, 64'd0, 1'b1)});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1,
			ent(1, '1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1)});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1,
			ent(2, 31'h7FFF_FFFE, '1, 1'b1, 1'b1)});
		dir.push_back('{KIND_LOAD, 11'd0, 31'd9, 64'd9, 1'b0, '0});
		dir.push_back('{KIND_LOAD, '1, 31'd9, 64'd9, 1'b0, '0});
		dir.push_back('{KIND_LOAD, 11'd3, 31'd9, 64'd9, 1'b0, '0});
		dir.push_back('{KIND_LOAD, 11'd2, 31'd5, 64'd1, 1'b0, '0});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1, rp(0, 0, 1'b1)});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1, rp(1, 0, 1'b1)});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1, rp(2, 1, 1'b1)});
		dir.push_back('{KIND_DRAIN, 11'd0, 31'd0, 64'd0, 1'b1,
			ent(0, 31'd4, 64'd1, 1'b1, 1'b1)});
		foreach (dir[i])
			send_word(dir[i].kind, dir[i].row, dir[i].col, dir[i].value,
				dir[i].typed, dir[i].res);
		wait_settled();

		items_sent = 0;
		batch = 0;
		while (items_sent < RAND_ITEMS) begin
			fast_send = ($urandom_range(0, 3) == 0);
			if (batch == 0 || batch == 6 || $urandom_range(0, 1) == 1) begin
				wait_settled();
				case ($urandom_range(0, 19))
					0: set_rows(0);
					1: set_rows(1);
					2: set_rows($urandom_range(17, 200));
					default: set_rows($urandom_range(2, 16));
				endcase
				// rows above range act as the maximum
				if (batch == 6)
					set_rows(ROWS_TOP);
			end
			loads = $urandom_range(0, 30);
			repeat (loads)
				send_word(KIND_LOAD, rand_row(), rand_col(), {$urandom(), $urandom()});
			if (batch != 6 && $urandom_range(0, 4) == 0) begin
				wait_settled();
				set_rows($urandom_range(0, cfg_rows));
			end
			if (batch == 6)
				long_hold = 1;
			do begin
				if ($urandom_range(0, 19) == 0)
					send_word(KIND_LOAD, rand_row(), rand_col(), {$urandom(), $urandom()});
				else
					send_word(KIND_DRAIN, ROW_W'($urandom()), COL_W'($urandom()),
						{$urandom(), $urandom()});
				if (batch == 3 && drain_pos == 2) begin
					in_ch.valid <= 1'b0;
					while (csr_expected.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(0, 29) == 0)
					idle_word();
			end while (draining);
			batch++;
		end
		in_ch.valid <= 1'b0;
		while (csr_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (csr_expected.size() != 0)
			errors++;
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[coo_to_csr_converter.f]
hdl/coo2csr_pkg.sv
hdl/coo2csr_if.sv
hdl/coo2csr_front.sv
hdl/coo2csr_queue.sv
hdl/coo2csr_back.sv
hdl/coo_to_csr_converter.sv
dv/tb_coo_to_csr_converter.sv
